/* rtl/rgbhsv_pkg.sv */
package rgbhsv_pkg;

    localparam int PIX_W      = 8;
    localparam int HUE_W      = 9;
    localparam int SAT_W      = 7;
    // hue numerator: 60*255 + 360*255 fits in 17 bits
    localparam int HNUM_W     = 17;
    // saturation numerator: 100*255 fits in 15 bits
    localparam int SNUM_W     = 15;
    localparam int PASS_STEPS = 3;
    localparam int PASSES     = 3;
    localparam int NSTAGE     = PASSES + 1;

    localparam logic [HNUM_W-1:0] K_60  = HNUM_W'(60);
    localparam logic [HNUM_W-1:0] K_120 = HNUM_W'(120);
    localparam logic [HNUM_W-1:0] K_240 = HNUM_W'(240);
    localparam logic [HNUM_W-1:0] K_360 = HNUM_W'(360);
    localparam logic [SNUM_W-1:0] K_100 = SNUM_W'(100);
    localparam logic [HUE_W-1:0]  HUE_WRAP = HUE_W'(360);

    // One in-flight pixel: partial remainders and quotients of both
    // divisions, their divisors, and the value channel.
    typedef struct packed {
        logic [HNUM_W-1:0] hrem;
        logic [SNUM_W-1:0] srem;
        logic [HUE_W-1:0]  hq;
        logic [SAT_W-1:0]  sq;
        logic [PIX_W-1:0]  hdiv;
        logic [PIX_W-1:0]  sdiv;
    } t_div;

endpackage

/* rtl/rgb_to_hsv_pixel.sv */
// RGB to HSV pixel converter. Takes one 8-bit RGB pixel per transfer and
// returns hue in whole degrees (0..359, 0 for grey), saturation in whole
// percent (truncated, 0 for black) and value (the largest channel). The
// block accepts one pixel every clock while a stalled output does not hold it:
// one stage finds max, min and the two numerators, then three stages each
// retire three quotient bits of the hue division (by max - min) and up to
// three of the saturation division (by max; its last stage retires only
// one) in restoring long-division steps. The last
// stage doubles as the output register; every stage holds its pixel while
// the one after it is full and held, so a stalled output never blocks
// pixels still filling the earlier stages.
module rgb_to_hsv_pixel (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [rgbhsv_pkg::PIX_W-1:0] i_red,
    input  logic [rgbhsv_pkg::PIX_W-1:0] i_green,
    input  logic [rgbhsv_pkg::PIX_W-1:0] i_blue,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [rgbhsv_pkg::HUE_W-1:0] o_hue,
    output logic [rgbhsv_pkg::SAT_W-1:0] o_saturation,
    output logic [rgbhsv_pkg::PIX_W-1:0] o_brightness
);
    import rgbhsv_pkg::*;

    // pipeline registers; the value channel rides along as the sat divisor
    t_div             r_st  [NSTAGE];
    logic [NSTAGE-1:0] r_vld;
    logic [NSTAGE-1:0] w_adv;

    // front end
    logic [PIX_W-1:0]  w_mx;
    logic [PIX_W-1:0]  w_mn;
    logic [PIX_W-1:0]  w_diff;
    logic [HNUM_W-1:0] w_hnum;
    t_div              n_st0;

    // division chains: step j of pass s
    t_div w_chain [PASSES][PASS_STEPS+1];

    // A stage advances when it is empty or its successor advances.
    always_comb begin
        w_adv[NSTAGE-1] = !r_vld[NSTAGE-1] || i_ready;
        for (int k = NSTAGE - 2; k >= 0; k--) begin
            w_adv[k] = !r_vld[k] || w_adv[k+1];
        end
    end
    assign o_ready = w_adv[0];

    always_comb begin
        w_mx = i_red;
        if (i_green > w_mx) w_mx = i_green;
        if (i_blue > w_mx) w_mx = i_blue;
        w_mn = i_red;
        if (i_green < w_mn) w_mn = i_green;
        if (i_blue < w_mn) w_mn = i_blue;
        w_diff = w_mx - w_mn;

        // Numerators stay non-negative: the subtracted channel never exceeds
        // the added one by more than diff. Ties for max go red, then green.
        if (w_mx == i_red) begin
            w_hnum = K_60 * HNUM_W'(i_green) + K_360 * HNUM_W'(w_diff)
                   - K_60 * HNUM_W'(i_blue);
        end else if (w_mx == i_green) begin
            w_hnum = K_60 * HNUM_W'(i_blue) + K_120 * HNUM_W'(w_diff)
                   - K_60 * HNUM_W'(i_red);
        end else begin
            w_hnum = K_60 * HNUM_W'(i_red) + K_240 * HNUM_W'(w_diff)
                   - K_60 * HNUM_W'(i_green);
        end

        n_st0.hrem = w_hnum;
        n_st0.srem = K_100 * SNUM_W'(w_diff);
        n_st0.hq   = '0;
        n_st0.sq   = '0;
        n_st0.hdiv = w_diff;
        n_st0.sdiv = w_mx;
    end

    // Restoring division: the quotient fits its field, so each step tests
    // the divisor shifted to one quotient bit, most significant first.
    for (genvar s = 0; s < PASSES; s++) begin : g_pass
        assign w_chain[s][0] = r_st[s];
        for (genvar j = 0; j < PASS_STEPS; j++) begin : g_step
            localparam int HB  = HUE_W - 1 - PASS_STEPS * s - j;
            localparam int SB  = SAT_W - 1 - PASS_STEPS * s - j;
            localparam int SBC = (SB >= 0) ? SB : 0;
            always_comb begin
                logic [HNUM_W-1:0] hsh;
                logic [SNUM_W-1:0] ssh;
                w_chain[s][j+1] = w_chain[s][j];
                hsh = HNUM_W'(w_chain[s][j].hdiv) << HB;
                ssh = SNUM_W'(w_chain[s][j].sdiv) << SBC;
                if (w_chain[s][j].hrem >= hsh) begin
                    w_chain[s][j+1].hrem   = w_chain[s][j].hrem - hsh;
                    w_chain[s][j+1].hq[HB] = 1'b1;
                end
                if (SB >= 0) begin
                    if (w_chain[s][j].srem >= ssh) begin
                        w_chain[s][j+1].srem    = w_chain[s][j].srem - ssh;
                        w_chain[s][j+1].sq[SBC] = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_adv[0]) r_vld[0] <= i_valid;
            for (int k = 1; k < NSTAGE; k++) begin
                if (w_adv[k]) r_vld[k] <= r_vld[k-1];
            end
        end
    end

    // payload: advance with the stage, hold otherwise
    always_ff @(posedge i_clk) begin
        if (w_adv[0]) r_st[0] <= n_st0;
        for (int k = 1; k < NSTAGE; k++) begin
            if (w_adv[k]) r_st[k] <= w_chain[k-1][PASS_STEPS];
        end
    end

    // Output: drop the quotient for grey and black pixels, wrap red hues.
    always_comb begin
        if (r_st[NSTAGE-1].hdiv == '0) begin
            o_hue = '0;
        end else if (r_st[NSTAGE-1].hq >= HUE_WRAP) begin
            o_hue = r_st[NSTAGE-1].hq - HUE_WRAP;
        end else begin
            o_hue = r_st[NSTAGE-1].hq;
        end
        o_saturation = (r_st[NSTAGE-1].sdiv == '0) ? '0 : r_st[NSTAGE-1].sq;
        o_brightness = r_st[NSTAGE-1].sdiv;
    end
    assign o_valid = r_vld[NSTAGE-1];

    a_hue_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_hue < HUE_WRAP))
        else $error("hue out of range");

    a_sat_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_saturation <= SAT_W'(100)))
        else $error("saturation out of range");

    a_grey_sat : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_st[NSTAGE-1].hdiv == '0) |-> (o_saturation == '0))
        else $error("grey pixel with nonzero saturation");

    a_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[NSTAGE-2] && r_vld[NSTAGE-1] && !i_ready) |=> r_vld[NSTAGE-2])
        else $error("stage lost a pixel under stall");

endmodule
